>>> rtl/core/mexi_pkg.sv
package mexi_pkg;

   localparam int RES_WIDTH = 30;
   localparam int EXP_WIDTH = 63;

   // the prime and the exponent that gives an inverse by fermat
   localparam logic [RES_WIDTH-1:0] MODULUS      = 30'd1000000007;
   localparam logic [EXP_WIDTH-1:0] INV_EXPONENT = 63'd1000000005;

   // barrett reduction with k = 30: mu = floor(2^60 / m)
   localparam logic [61:0] BARRETT_NUM = 62'h1 << 60;
   localparam logic [30:0] BARRETT_MU  = 31'(BARRETT_NUM / 62'(MODULUS));
   localparam logic [31:0] MOD_X1      = 32'(MODULUS);
   localparam logic [31:0] MOD_X2      = 32'(MODULUS) << 1;

   typedef enum logic {
      OP_POWER   = 1'b0,
      OP_INVERSE = 1'b1
   } mexi_op_type;

   // where a product from the multiplier is written back
   typedef enum logic {
      DEST_BASE = 1'b0,
      DEST_ACC  = 1'b1
   } mexi_dest_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_MULTIPLY,
      ST_DRAIN,
      ST_FINISH
   } mexi_state_type;

   typedef struct packed {
      logic                 valid;
      mexi_dest_type        dest;
      logic [RES_WIDTH-1:0] a;
      logic [RES_WIDTH-1:0] b;
   } mexi_mm_req_type;

   typedef struct packed {
      logic                 valid;
      mexi_dest_type        dest;
      logic [RES_WIDTH-1:0] value;
      logic                 busy;
   } mexi_mm_rsp_type;

endpackage

>>> rtl/core/mexi_chan_if.sv
interface mexi_req_if import mexi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [RES_WIDTH-1:0] base;
   logic [EXP_WIDTH-1:0] exponent;

   modport source (output valid, output op, output base, output exponent, input ready);
   modport sink (input valid, input op, input base, input exponent, output ready);
endinterface

interface mexi_rsp_if import mexi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [RES_WIDTH-1:0] result;
   logic                 error;

   modport source (output valid, output result, output error, input ready);
   modport sink (input valid, input result, input error, output ready);
endinterface

>>> rtl/core/mexi_mulmod.sv
module mexi_mulmod import mexi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  mexi_mm_req_type mm_req,
   output mexi_mm_rsp_type mm_rsp
);

   logic [59:0]          prod_ff, prod_in;
   logic [30:0]          quo_ff, quo_in;
   logic [31:0]          plo_ff, plo_in;
   logic [31:0]          rem_ff, rem_in;
   logic [RES_WIDTH-1:0] value_ff, value_in;
   logic [61:0]          q2;
   logic [31:0]          qm;
   logic [3:0]           valid_ff;
   mexi_dest_type        dest1_ff, dest2_ff, dest3_ff, dest4_ff;

   always_comb begin
      prod_in = 60'(mm_req.a) * 60'(mm_req.b);
      // quotient estimate from the top bits of the product
      q2      = 62'(prod_ff[59:29]) * 62'(BARRETT_MU);
      quo_in  = q2[61:31];
      plo_in  = prod_ff[31:0];
      // remainder is below 3m, so 32 bits are enough
      qm      = 32'(quo_ff) * MOD_X1;
      rem_in  = plo_ff - qm;
      if (rem_ff >= MOD_X2) begin
         value_in = RES_WIDTH'(rem_ff - MOD_X2);
      end else if (rem_ff >= MOD_X1) begin
         value_in = RES_WIDTH'(rem_ff - MOD_X1);
      end else begin
         value_in = RES_WIDTH'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], mm_req.valid};
      end
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      plo_ff   <= plo_in;
      rem_ff   <= rem_in;
      value_ff <= value_in;
      dest1_ff <= mm_req.dest;
      dest2_ff <= dest1_ff;
      dest3_ff <= dest2_ff;
      dest4_ff <= dest3_ff;
   end

   assign mm_rsp.valid = valid_ff[3];
   assign mm_rsp.dest  = dest4_ff;
   assign mm_rsp.value = value_ff;
   assign mm_rsp.busy  = |valid_ff;

   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |=> valid_ff[1])
      else $error("mulmod stage lost its operand");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> rem_ff < (MOD_X2 + MOD_X1))
      else $error("barrett remainder out of range");

   a_value_bound: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.valid |-> mm_rsp.value < MODULUS)
      else $error("mulmod result not reduced");

endmodule

>>> rtl/core/modular_exponentiation_inverse.sv
// Modular power and inverse modulo the prime 1000000007. An item with op 0 returns
// base^exponent (exponent of zero gives 1), an item with op 1 returns the inverse of
// base as base^(1000000005); the inverse of zero returns 0 with error set. A base at
// or above the modulus is reduced first. One item is worked at a time: req ready is
// high only while the sequencer is idle, and each item gives exactly one rsp item,
// held in an output register so the next item can be taken while it waits. Timing is
// set by the four-stage barrett multiplier, shared by squarings and multiplies: each
// exponent bit up to the highest set one costs a squaring, and a multiply as well when
// the bit is set, and the sequencer drains both products before the next bit; an
// exponent of zero or an inverse of zero skips the loop and goes straight to finish.
module modular_exponentiation_inverse import mexi_pkg::*; (
   input logic     clock,
   input logic     reset,
   mexi_req_if.sink   req_chan,
   mexi_rsp_if.source rsp_chan
);

   mexi_state_type       state_ff, state_in;
   logic [RES_WIDTH-1:0] base_ff, base_in;
   logic [RES_WIDTH-1:0] acc_ff, acc_in;
   logic [EXP_WIDTH-1:0] exp_ff, exp_in;
   logic                 err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RES_WIDTH-1:0] result_ff, result_in;
   logic                 error_ff, error_in;
   logic [RES_WIDTH-1:0] base_red;
   logic                 load_rsp;
   mexi_mm_req_type      mm_req;
   mexi_mm_rsp_type      mm_rsp;

   mexi_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign base_red = (req_chan.base >= MODULUS) ? (req_chan.base - MODULUS) : req_chan.base;

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      exp_in   = exp_ff;
      err_in   = err_ff;
      load_rsp = 1'b0;
      mm_req   = '{valid: 1'b0, dest: DEST_BASE, a: base_ff, b: base_ff};
      req_chan.ready = 1'b0;

      // products come back while the sequencer waits
      if (mm_rsp.valid) begin
         if (mm_rsp.dest == DEST_ACC) begin
            acc_in = mm_rsp.value;
         end else begin
            base_in = mm_rsp.value;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               base_in = base_red;
               acc_in  = RES_WIDTH'(1);
               err_in  = 1'b0;
               if (mexi_op_type'(req_chan.op) == OP_INVERSE) begin
                  exp_in = INV_EXPONENT;
                  if (base_red == '0) begin
                     acc_in = '0;
                     err_in = 1'b1;
                  end
               end else begin
                  exp_in = req_chan.exponent;
               end
               if (err_in || exp_in == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            mm_req = '{valid: 1'b1, dest: DEST_BASE, a: base_ff, b: base_ff};
            state_in = exp_ff[0] ? ST_MULTIPLY : ST_DRAIN;
         end
         ST_MULTIPLY: begin
            // base_ff still holds the old base, the square is in flight
            mm_req = '{valid: 1'b1, dest: DEST_ACC, a: acc_ff, b: base_ff};
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!mm_rsp.busy) begin
               exp_in   = exp_ff >> 1;
               state_in = (exp_in == '0) ? ST_FINISH : ST_SQUARE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_chan.ready);
      result_in    = load_rsp ? acc_ff : result_ff;
      error_in     = load_rsp ? err_ff : error_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
      err_ff    <= err_in;
      result_ff <= result_in;
      error_ff  <= error_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = result_ff;
   assign rsp_chan.error  = error_ff;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.error |-> rsp_chan.result == '0)
      else $error("error item with non-zero result");

   a_wb_in_work: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.valid |-> (state_ff == ST_MULTIPLY || state_ff == ST_DRAIN))
      else $error("product returned outside the exponent loop");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff != ST_IDLE)
      else $error("item accepted but sequencer stayed idle");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.result < MODULUS)
      else $error("result not reduced");

endmodule

>>> tb/tb_top.sv
module tb_top import mexi_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CALM_TAIL    = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 500;

   localparam logic [RES_WIDTH-1:0] BASE_MAX = {RES_WIDTH{1'b1}};
   localparam logic [EXP_WIDTH-1:0] EXP_MAX  = {EXP_WIDTH{1'b1}};

   typedef struct {
      mexi_op_type          op;
      logic [RES_WIDTH-1:0] base;
      logic [EXP_WIDTH-1:0] exponent;
      bit                   wait_drain;
   } request_type;

   typedef struct packed {
      logic [RES_WIDTH-1:0] result;
      logic                 error;
   } residue_type;

   logic clock;
   logic reset;

   mexi_req_if req_bus ();
   mexi_rsp_if rsp_bus ();

   modular_exponentiation_inverse uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   request_type request_queue[$];
   residue_type residue_queue[$];

   int items_sent   = 0;
   int error_count  = 0;
   int send_gap     = 0;
   int take_gap     = 0;
   int stall_cycles = 0;

   // square-and-multiply from the low exponent bit, inverse by fermat
   function automatic residue_type predict_residue(logic op, logic [RES_WIDTH-1:0] base,
                                                   logic [EXP_WIDTH-1:0] exponent);
      longint unsigned b;
      longint unsigned acc;
      logic [EXP_WIDTH-1:0] e;
      residue_type r;
      b = 64'(base) % 64'(MODULUS);
      acc = 64'd1;
      r.error = 1'b0;
      e = (op == OP_INVERSE) ? INV_EXPONENT : exponent;
      if (op == OP_INVERSE && b == 64'd0) begin
         r.error = 1'b1;
         acc = 64'd0;
      end else begin
         while (e != '0) begin
            if (e[0])
               acc = (acc * b) % 64'(MODULUS);
            b = (b * b) % 64'(MODULUS);
            e = e >> 1;
         end
      end
      r.result = acc[RES_WIDTH-1:0];
      return r;
   endfunction

   // idle pressure varies in stretches of 150 items, none in the tail
   function automatic int idle_percent();
      if (request_queue.size() < CALM_TAIL)
         return 0;
      case ((items_sent / 150) % 4)
         0: return 0;
         1: return 15;
         2: return 40;
         default: return 70;
      endcase
   endfunction

   task automatic add_request(mexi_op_type op, logic [RES_WIDTH-1:0] base,
                              logic [EXP_WIDTH-1:0] exponent, bit wait_drain);
      request_type item;
      item.op = op;
      item.base = base;
      item.exponent = exponent;
      item.wait_drain = wait_drain;
      request_queue = {request_queue, item};
   endtask

   task automatic fill_random();
      mexi_op_type op;
      logic [RES_WIDTH-1:0] base;
      logic [EXP_WIDTH-1:0] exponent;
      int width;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op = ($urandom_range(99, 0) < 30) ? OP_INVERSE : OP_POWER;
         case ($urandom_range(9, 0))
            0: base = RES_WIDTH'($urandom_range(3, 0));
            1: base = RES_WIDTH'($urandom);
            2: base = RES_WIDTH'($urandom_range(32'(BASE_MAX), 32'(MODULUS) - 3));
            default: base = RES_WIDTH'($urandom_range(32'(MODULUS) - 1, 0));
         endcase
         width = $urandom_range(EXP_WIDTH, 0);
         if ($urandom_range(9, 0) == 0)
            exponent = EXP_MAX;
         else
            exponent = EXP_WIDTH'({$urandom, $urandom});
         if (width < EXP_WIDTH)
            exponent = exponent & ((EXP_WIDTH'(1) << width) - 1);
         add_request(op, base, exponent, (i == 0) || ($urandom_range(99, 0) == 0));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5ns clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      request_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            residue_queue = {residue_queue, predict_residue(req_bus.op, req_bus.base,
                                                            req_bus.exponent)};
            items_sent++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // item still waiting, hold it
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (request_queue.size() == 0 ||
                      (request_queue[0].wait_drain && residue_queue.size() != 0)) begin
            req_bus.valid <= 1'b0;
         end else if ($urandom_range(99, 0) < idle_percent()) begin
            send_gap <= $urandom_range(7, 0);
            req_bus.valid <= 1'b0;
         end else begin
            item = request_queue.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.op <= item.op;
            req_bus.base <= item.base;
            req_bus.exponent <= item.exponent;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      residue_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         take_gap <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (residue_queue.size() == 0) begin
               $error("result item with nothing outstanding: result %0d error %0b",
                      rsp_bus.result, rsp_bus.error);
               error_count++;
            end else begin
               want = residue_queue.pop_front();
               if (rsp_bus.result !== want.result) begin
                  $error("result: expected %0d, got %0d", want.result, rsp_bus.result);
                  error_count++;
               end
               if (rsp_bus.error !== want.error) begin
                  $error("error: expected %0b, got %0b", want.error, rsp_bus.error);
                  error_count++;
               end
            end
         end
         if (take_gap != 0) begin
            take_gap <= take_gap - 1;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(99, 0) < idle_percent()) begin
            take_gap <= $urandom_range(7, 0);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_POWER;
      req_bus.base = '0;
      req_bus.exponent = '0;
      rsp_bus.ready = 1'b0;

      // zero, one and m-1 base corners, including zero to the power zero
      add_request(OP_POWER, '0, '0, 1'b0);
      add_request(OP_POWER, '0, EXP_WIDTH'(1), 1'b0);
      add_request(OP_POWER, '0, EXP_MAX, 1'b0);
      add_request(OP_POWER, RES_WIDTH'(1), EXP_MAX, 1'b0);
      add_request(OP_POWER, MODULUS - 1, EXP_MAX, 1'b0);
      add_request(OP_POWER, MODULUS - 1, EXP_WIDTH'(2), 1'b0);
      add_request(OP_POWER, MODULUS - 1, '0, 1'b0);
      // bases at or above the modulus wrap first; then plain bases with assorted exponents
      add_request(OP_POWER, MODULUS, EXP_WIDTH'(5), 1'b0);
      add_request(OP_POWER, MODULUS, '0, 1'b0);
      add_request(OP_POWER, BASE_MAX, EXP_MAX, 1'b0);
      add_request(OP_POWER, RES_WIDTH'(2), EXP_WIDTH'(1), 1'b1);
      add_request(OP_POWER, RES_WIDTH'(2), EXP_WIDTH'(1) << 62, 1'b0);
      add_request(OP_POWER, RES_WIDTH'(12345), '0, 1'b0);
      add_request(OP_POWER, RES_WIDTH'(987654321), EXP_WIDTH'(MODULUS - 1), 1'b0);
      add_request(OP_POWER, RES_WIDTH'(987654321), INV_EXPONENT, 1'b0);
      // inverse of zero, plain and after the wrap, then nonzero inverses
      add_request(OP_INVERSE, '0, '0, 1'b0);
      add_request(OP_INVERSE, MODULUS, EXP_MAX, 1'b0);
      add_request(OP_INVERSE, RES_WIDTH'(1), '0, 1'b0);
      add_request(OP_INVERSE, MODULUS - 1, '0, 1'b0);
      add_request(OP_INVERSE, BASE_MAX, '0, 1'b0);
      add_request(OP_INVERSE, RES_WIDTH'(2), EXP_MAX, 1'b0);
      add_request(OP_INVERSE, RES_WIDTH'(3), '0, 1'b0);
      fill_random();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_bus.valid || residue_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && residue_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
